@@ design/shape_pair_collision_resolve_core_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the shape pair collision core
// Clocked on clk_i, disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef SHAPE_PAIR_COLLISION_RESOLVE_CORE_ASSERT_SVH
`define SHAPE_PAIR_COLLISION_RESOLVE_CORE_ASSERT_SVH

// Check a property on every rising edge outside reset.
`define SPCR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that a condition never holds.
`define SPCR_NEVER(lbl, expr, msg) \
  `SPCR_ASSERT(lbl, !(expr), msg)

`endif

@@ design/spcr_pkg.sv @@
// ---------------------------------------------------------------------------
// spcr_pkg
// Types, widths and helpers shared by the shape pair collision core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package spcr_pkg;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_BOX    = 2'd1,
    KIND_CIRCLE = 2'd2
  } kind_e;

  localparam int unsigned POS_W      = 24;
  localparam int unsigned HALF_W     = 22;
  localparam int unsigned DIFF_W     = 25;
  localparam int unsigned SUM_W      = 23;
  localparam int unsigned OVB_W      = 26;
  localparam int unsigned SQD_W      = 48;
  localparam int unsigned RS2_W      = 46;
  localparam int unsigned SQ_W       = 50;
  localparam int unsigned ROOT_W     = 25;
  localparam int unsigned SREM_W     = 28;
  localparam int unsigned OV_W       = 26;
  localparam int unsigned PROD_W     = 51;
  localparam int unsigned NUM_W      = 50;
  localparam int unsigned DEN_W      = 26;
  localparam int unsigned Q_W        = 26;
  localparam int unsigned DREM_W     = 27;
  localparam int unsigned EXT_W      = 28;
  localparam int unsigned SQRT_STEPS = 25;
  localparam int unsigned DIV_STEPS  = 26;

  localparam int unsigned IN_DATA_W  = 184;
  localparam int unsigned IN_USER_W  = 4;
  localparam int unsigned OUT_DATA_W = 96;
  localparam int unsigned OUT_USER_W = 2;

  // Pipeline stage map
  localparam int unsigned ST_IN    = 0;
  localparam int unsigned ST_OVL   = 1;
  localparam int unsigned ST_SEL   = 2;
  localparam int unsigned ST_SQ0   = 3;
  localparam int unsigned ST_SQN   = ST_SQ0 + SQRT_STEPS - 1;
  localparam int unsigned ST_OV    = ST_SQN + 1;
  localparam int unsigned ST_MUL   = ST_OV + 1;
  localparam int unsigned ST_NUM   = ST_MUL + 1;
  localparam int unsigned ST_DV0   = ST_NUM + 1;
  localparam int unsigned ST_DVN   = ST_DV0 + DIV_STEPS - 1;
  localparam int unsigned ST_OUT   = ST_DVN + 1;
  localparam int unsigned N_STAGES = ST_OUT + 1;

  typedef struct packed {
    logic                      box;
    logic                      circ;
    logic                      hit;
    logic                      degen;
    logic signed [POS_W-1:0]   ax;
    logic signed [POS_W-1:0]   ay;
    logic signed [POS_W-1:0]   bx;
    logic signed [POS_W-1:0]   by;
    logic signed [DIFF_W-1:0]  dx;
    logic signed [DIFF_W-1:0]  dy;
    logic [SUM_W-1:0]          rs;
    logic [SUM_W-1:0]          sx;
    logic [SUM_W-1:0]          sy;
    logic signed [OVB_W-1:0]   xov;
    logic signed [OVB_W-1:0]   yov;
    logic                      bhit;
    logic [SQD_W-1:0]          dx2;
    logic [SQD_W-1:0]          dy2;
    logic [RS2_W-1:0]          rs2;
    logic [SQ_W-1:0]           rad;
    logic [ROOT_W-1:0]         root;
    logic [SREM_W-1:0]         srem;
    logic signed [OV_W-1:0]    ov;
    logic [ROOT_W-1:0]         dlen;
    logic signed [PROD_W-1:0]  px;
    logic signed [PROD_W-1:0]  py;
    logic                      negx;
    logic                      negy;
    logic [NUM_W-1:0]          numx;
    logic [NUM_W-1:0]          numy;
    logic [DREM_W-1:0]         dremx;
    logic [DREM_W-1:0]         dremy;
    logic [Q_W-1:0]            qx;
    logic [Q_W-1:0]            qy;
  } stage_t;

  // Clamp a widened coordinate back into the Q15.8 range.
  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [EXT_W-1:0] v);
    logic signed [EXT_W-1:0] hi;
    logic signed [EXT_W-1:0] lo;
    hi = EXT_W'(signed'(24'sh7FFFFF));
    lo = EXT_W'(signed'(24'sh800000));
    if (v > hi) begin
      return 24'sh7FFFFF;
    end else if (v < lo) begin
      return 24'sh800000;
    end
    return POS_W'(v);
  endfunction

endpackage

@@ design/spcr_sqrt_step.sv @@
// ---------------------------------------------------------------------------
// spcr_sqrt_step
// One digit of a restoring integer square root: two radicand bits per step.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module spcr_sqrt_step import spcr_pkg::*; (
  input  logic [SQ_W-1:0]   rad_i,
  input  logic [ROOT_W-1:0] root_i,
  input  logic [SREM_W-1:0] srem_i,
  output logic [SQ_W-1:0]   rad_o,
  output logic [ROOT_W-1:0] root_o,
  output logic [SREM_W-1:0] srem_o
);

  logic [SREM_W-1:0] cur;
  logic [SREM_W-1:0] trial;

  assign cur   = {srem_i[SREM_W-3:0], rad_i[SQ_W-1 -: 2]};
  assign trial = {1'b0, root_i, 2'b01};
  assign rad_o = {rad_i[SQ_W-3:0], 2'b00};

  always_comb begin
    if (cur >= trial) begin
      srem_o = cur - trial;
      root_o = {root_i[ROOT_W-2:0], 1'b1};
    end else begin
      srem_o = cur;
      root_o = {root_i[ROOT_W-2:0], 1'b0};
    end
  end

endmodule

@@ design/spcr_div_step.sv @@
// ---------------------------------------------------------------------------
// spcr_div_step
// One bit of a restoring unsigned division.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module spcr_div_step import spcr_pkg::*; (
  input  logic [DEN_W-1:0]  den_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DREM_W-1:0] drem_i,
  input  logic [Q_W-1:0]    q_i,
  output logic [NUM_W-1:0]  num_o,
  output logic [DREM_W-1:0] drem_o,
  output logic [Q_W-1:0]    q_o
);

  logic [DREM_W-1:0] cur;
  logic [DREM_W-1:0] den_ext;

  assign cur     = {drem_i[DREM_W-2:0], num_i[DIV_STEPS-1]};
  assign den_ext = {1'b0, den_i};
  assign num_o   = {num_i[NUM_W-2:0], 1'b0};

  always_comb begin
    if (cur >= den_ext) begin
      drem_o = cur - den_ext;
      q_o    = {q_i[Q_W-2:0], 1'b1};
    end else begin
      drem_o = cur;
      q_o    = {q_i[Q_W-2:0], 1'b0};
    end
  end

endmodule

@@ design/shape_pair_collision_resolve_core.sv @@
// ---------------------------------------------------------------------------
// shape_pair_collision_resolve_core
// Box/box and circle/circle hit test with position resolution, fully pipelined.
// ---------------------------------------------------------------------------
//  channel   dir  tdata (low bit up)                               tuser
//  s_axis    in   a_x a_y a_half_x a_half_y b_x b_y b_half_x      kind_a kind_b
//                 b_half_y
//  m_axis    out  new_a_x new_a_y new_b_x new_b_y                  hit degenerate
//
//  One item per cycle while m_axis_tready is held high. The depth is set by
//  the 25-stage square root and the 26-stage divider, each retiring one
//  result bit per stage.
//  Reset clears only the stage valid bits; payload registers are not reset.
//  Each stage loads when it is empty or the stage after it loads, so a stall
//  at m_axis fills bubbles before it reaches s_axis.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module shape_pair_collision_resolve_core import spcr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // a_x, a_y, a_half_x, a_half_y, b_x, b_y, b_half_x, b_half_y
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // kind_a, kind_b
  input  logic [IN_USER_W-1:0]  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // new_a_x, new_a_y, new_b_x, new_b_y
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // hit, degenerate
  output logic [OUT_USER_W-1:0] m_axis_tuser
);

  stage_t              pipe_q [N_STAGES];
  stage_t              pipe_d [N_STAGES];
  logic [N_STAGES-1:0] valid_q;
  logic [N_STAGES-1:0] en;

  // Input field unpack
  logic [1:0]              kind_a;
  logic [1:0]              kind_b;
  logic signed [POS_W-1:0] a_x, a_y, b_x, b_y;
  logic [HALF_W-1:0]       a_half_x, a_half_y, b_half_x, b_half_y;

  assign a_x      = s_axis_tdata[23:0];
  assign a_y      = s_axis_tdata[47:24];
  assign a_half_x = s_axis_tdata[69:48];
  assign a_half_y = s_axis_tdata[91:70];
  assign b_x      = s_axis_tdata[115:92];
  assign b_y      = s_axis_tdata[139:116];
  assign b_half_x = s_axis_tdata[161:140];
  assign b_half_y = s_axis_tdata[183:162];
  assign kind_a   = s_axis_tuser[1:0];
  assign kind_b   = s_axis_tuser[3:2];

  // Stage enables: load when empty or when the next stage loads.
  assign en[N_STAGES-1] = !valid_q[N_STAGES-1] || m_axis_tready;
  for (genvar k = 0; k < N_STAGES - 1; k++) begin : g_en
    assign en[k] = !valid_q[k] || en[k+1];
  end
  assign s_axis_tready = en[0];

  // Stage 0: capture, centre differences and size sums
  always_comb begin
    pipe_d[ST_IN]      = '0;
    pipe_d[ST_IN].box  = (kind_a == KIND_BOX) && (kind_b == KIND_BOX);
    pipe_d[ST_IN].circ = (kind_a == KIND_CIRCLE) && (kind_b == KIND_CIRCLE);
    pipe_d[ST_IN].ax   = a_x;
    pipe_d[ST_IN].ay   = a_y;
    pipe_d[ST_IN].bx   = b_x;
    pipe_d[ST_IN].by   = b_y;
    pipe_d[ST_IN].dx   = {b_x[POS_W-1], b_x} - {a_x[POS_W-1], a_x};
    pipe_d[ST_IN].dy   = {b_y[POS_W-1], b_y} - {a_y[POS_W-1], a_y};
    pipe_d[ST_IN].rs   = {1'b0, a_half_x} + {1'b0, b_half_x};
    pipe_d[ST_IN].sx   = {1'b0, a_half_x} + {1'b0, b_half_x};
    pipe_d[ST_IN].sy   = {1'b0, a_half_y} + {1'b0, b_half_y};
  end

  for (genvar k = 1; k < N_STAGES; k++) begin : g_st
    if (k == ST_OVL) begin : g_ovl
      // Box overlaps and hit; squares for the circle test.
      logic [DIFF_W-1:0] adx;
      logic [DIFF_W-1:0] ady;
      assign adx = pipe_q[k-1].dx[DIFF_W-1] ? DIFF_W'(-pipe_q[k-1].dx)
                                            : DIFF_W'(pipe_q[k-1].dx);
      assign ady = pipe_q[k-1].dy[DIFF_W-1] ? DIFF_W'(-pipe_q[k-1].dy)
                                            : DIFF_W'(pipe_q[k-1].dy);
      always_comb begin
        pipe_d[k]      = pipe_q[k-1];
        pipe_d[k].xov  = signed'({3'b000, pipe_q[k-1].sx}) - signed'({1'b0, adx});
        pipe_d[k].yov  = signed'({3'b000, pipe_q[k-1].sy}) - signed'({1'b0, ady});
        pipe_d[k].bhit = ({2'b00, pipe_q[k-1].sx} >= adx) &&
                         ({2'b00, pipe_q[k-1].sy} >= ady);
        pipe_d[k].dx2  = SQD_W'(adx[DIFF_W-2:0] * adx[DIFF_W-2:0]);
        pipe_d[k].dy2  = SQD_W'(ady[DIFF_W-2:0] * ady[DIFF_W-2:0]);
        pipe_d[k].rs2  = RS2_W'(pipe_q[k-1].rs * pipe_q[k-1].rs);
      end
    end else if (k == ST_SEL) begin : g_sel
      // Resolve boxes here; form the circle distance and its test.
      always_comb begin
        logic signed [EXT_W-1:0] sa;
        logic [SQ_W-1:0]         d2;
        pipe_d[k] = pipe_q[k-1];
        sa        = '0;
        d2        = {2'b00, pipe_q[k-1].dx2} + {2'b00, pipe_q[k-1].dy2};
        pipe_d[k].rad   = d2;
        pipe_d[k].root  = '0;
        pipe_d[k].srem  = '0;
        pipe_d[k].hit   = 1'b0;
        pipe_d[k].degen = 1'b0;
        if (pipe_q[k-1].box) begin
          pipe_d[k].hit = pipe_q[k-1].bhit;
          if (pipe_q[k-1].xov < pipe_q[k-1].yov) begin
            // push along x, away from B; equal centres push positive
            if (!pipe_q[k-1].dx[DIFF_W-1] && (pipe_q[k-1].dx != '0)) begin
              sa = EXT_W'(pipe_q[k-1].ax) - EXT_W'(pipe_q[k-1].xov);
            end else begin
              sa = EXT_W'(pipe_q[k-1].ax) + EXT_W'(pipe_q[k-1].xov);
            end
            pipe_d[k].ax = sat_pos(sa);
          end else begin
            if (!pipe_q[k-1].dy[DIFF_W-1] && (pipe_q[k-1].dy != '0)) begin
              sa = EXT_W'(pipe_q[k-1].ay) - EXT_W'(pipe_q[k-1].yov);
            end else begin
              sa = EXT_W'(pipe_q[k-1].ay) + EXT_W'(pipe_q[k-1].yov);
            end
            pipe_d[k].ay = sat_pos(sa);
          end
        end else if (pipe_q[k-1].circ) begin
          pipe_d[k].hit   = (d2 <= {4'b0000, pipe_q[k-1].rs2});
          pipe_d[k].degen = (d2 == '0);
        end
      end
    end else if (k >= ST_SQ0 && k <= ST_SQN) begin : g_sq
      // One root digit per stage.
      logic [SQ_W-1:0]   rad_n;
      logic [ROOT_W-1:0] root_n;
      logic [SREM_W-1:0] srem_n;
      spcr_sqrt_step u_sqrt (
        .rad_i  (pipe_q[k-1].rad),
        .root_i (pipe_q[k-1].root),
        .srem_i (pipe_q[k-1].srem),
        .rad_o  (rad_n),
        .root_o (root_n),
        .srem_o (srem_n)
      );
      always_comb begin
        pipe_d[k]      = pipe_q[k-1];
        pipe_d[k].rad  = rad_n;
        pipe_d[k].root = root_n;
        pipe_d[k].srem = srem_n;
      end
    end else if (k == ST_OV) begin : g_ov
      always_comb begin
        pipe_d[k]      = pipe_q[k-1];
        pipe_d[k].dlen = pipe_q[k-1].root;
        pipe_d[k].ov   = signed'({3'b000, pipe_q[k-1].rs}) -
                         signed'({1'b0, pipe_q[k-1].root});
      end
    end else if (k == ST_MUL) begin : g_mul
      always_comb begin
        pipe_d[k]    = pipe_q[k-1];
        pipe_d[k].px = pipe_q[k-1].ov * pipe_q[k-1].dx;
        pipe_d[k].py = pipe_q[k-1].ov * pipe_q[k-1].dy;
      end
    end else if (k == ST_NUM) begin : g_num
      // Magnitudes plus the distance give round-to-nearest after division by twice it.
      always_comb begin
        logic [PROD_W-1:0] magx;
        logic [PROD_W-1:0] magy;
        logic [NUM_W-1:0]  nx;
        logic [NUM_W-1:0]  ny;
        magx = pipe_q[k-1].px[PROD_W-1] ? PROD_W'(-pipe_q[k-1].px)
                                        : PROD_W'(pipe_q[k-1].px);
        magy = pipe_q[k-1].py[PROD_W-1] ? PROD_W'(-pipe_q[k-1].py)
                                        : PROD_W'(pipe_q[k-1].py);
        nx   = magx[NUM_W-1:0] + NUM_W'(pipe_q[k-1].dlen);
        ny   = magy[NUM_W-1:0] + NUM_W'(pipe_q[k-1].dlen);
        pipe_d[k]       = pipe_q[k-1];
        pipe_d[k].negx  = pipe_q[k-1].px[PROD_W-1];
        pipe_d[k].negy  = pipe_q[k-1].py[PROD_W-1];
        pipe_d[k].numx  = nx;
        pipe_d[k].numy  = ny;
        pipe_d[k].dremx = DREM_W'(nx[NUM_W-1:DIV_STEPS]);
        pipe_d[k].dremy = DREM_W'(ny[NUM_W-1:DIV_STEPS]);
        pipe_d[k].qx    = '0;
        pipe_d[k].qy    = '0;
      end
    end else if (k >= ST_DV0 && k <= ST_DVN) begin : g_dv
      // One quotient bit per stage for each axis.
      logic [NUM_W-1:0]  numx_n, numy_n;
      logic [DREM_W-1:0] dremx_n, dremy_n;
      logic [Q_W-1:0]    qx_n, qy_n;
      logic [DEN_W-1:0]  den;
      assign den = {pipe_q[k-1].dlen, 1'b0};
      spcr_div_step u_divx (
        .den_i  (den),
        .num_i  (pipe_q[k-1].numx),
        .drem_i (pipe_q[k-1].dremx),
        .q_i    (pipe_q[k-1].qx),
        .num_o  (numx_n),
        .drem_o (dremx_n),
        .q_o    (qx_n)
      );
      spcr_div_step u_divy (
        .den_i  (den),
        .num_i  (pipe_q[k-1].numy),
        .drem_i (pipe_q[k-1].dremy),
        .q_i    (pipe_q[k-1].qy),
        .num_o  (numy_n),
        .drem_o (dremy_n),
        .q_o    (qy_n)
      );
      always_comb begin
        pipe_d[k]       = pipe_q[k-1];
        pipe_d[k].numx  = numx_n;
        pipe_d[k].numy  = numy_n;
        pipe_d[k].dremx = dremx_n;
        pipe_d[k].dremy = dremy_n;
        pipe_d[k].qx    = qx_n;
        pipe_d[k].qy    = qy_n;
      end
    end else begin : g_out
      // Apply signed circle offsets; A moves back, B moves forward.
      always_comb begin
        logic signed [Q_W:0] offx;
        logic signed [Q_W:0] offy;
        offx = pipe_q[k-1].negx ? -signed'({1'b0, pipe_q[k-1].qx})
                                :  signed'({1'b0, pipe_q[k-1].qx});
        offy = pipe_q[k-1].negy ? -signed'({1'b0, pipe_q[k-1].qy})
                                :  signed'({1'b0, pipe_q[k-1].qy});
        pipe_d[k] = pipe_q[k-1];
        if (pipe_q[k-1].circ && !pipe_q[k-1].degen) begin
          pipe_d[k].ax = sat_pos(EXT_W'(pipe_q[k-1].ax) - EXT_W'(offx));
          pipe_d[k].ay = sat_pos(EXT_W'(pipe_q[k-1].ay) - EXT_W'(offy));
          pipe_d[k].bx = sat_pos(EXT_W'(pipe_q[k-1].bx) + EXT_W'(offx));
          pipe_d[k].by = sat_pos(EXT_W'(pipe_q[k-1].by) + EXT_W'(offy));
        end
      end
    end
  end

  // Valid bits: advance on enable.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < N_STAGES; k++) begin
        if (en[k]) begin
          valid_q[k] <= (k == 0) ? s_axis_tvalid : valid_q[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  // Payload: hold when the stage is stalled.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < N_STAGES; k++) begin
      if (en[k]) begin
        pipe_q[k] <= pipe_d[k];
      end
    end
  end

  assign m_axis_tvalid = valid_q[N_STAGES-1];
  assign m_axis_tdata  = {pipe_q[N_STAGES-1].by, pipe_q[N_STAGES-1].bx,
                          pipe_q[N_STAGES-1].ay, pipe_q[N_STAGES-1].ax};
  assign m_axis_tuser  = {pipe_q[N_STAGES-1].degen, pipe_q[N_STAGES-1].hit};

endmodule

@@ design/spcr_checker.sv @@
// ---------------------------------------------------------------------------
// spcr_checker
// Port-level checks for the shape pair collision core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "shape_pair_collision_resolve_core_assert.svh"

module spcr_checker import spcr_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [IN_DATA_W-1:0]  s_axis_tdata,
  input logic [IN_USER_W-1:0]  s_axis_tuser,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [OUT_USER_W-1:0] m_axis_tuser
);

  // a stalled result stays offered
  `SPCR_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped while stalled")

  // and its payload holds
  `SPCR_ASSERT(a_out_stable, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

  // a waiting input item keeps its payload
  `SPCR_ASSERT(a_in_stable,
    s_axis_tvalid && !s_axis_tready |=>
      s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser),
    "input item changed while waiting")

  // coincident centres always touch
  `SPCR_NEVER(a_degen_hit, m_axis_tvalid && m_axis_tuser[1] && !m_axis_tuser[0], "degenerate without hit")

  // a free output frees the whole pipe
  `SPCR_ASSERT(a_ready_flow, m_axis_tready |-> s_axis_tready, "input blocked with output free")

endmodule

bind shape_pair_collision_resolve_core spcr_checker u_spcr_checker (.*);
